[hw/rtl/gsl_pkg.sv]
`timescale 1ns / 1ps

package gsl_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_LOAD_GLYPH = 2'd0,
    FUNC_LOAD_PAL   = 2'd1,
    FUNC_START      = 2'd2,
    FUNC_CHAR       = 2'd3
  } func_e;

  // Configuration register indexes (byte address bit 2)
  localparam logic REG_PAL_CODES_EN = 1'b0;
  localparam logic REG_PAL_ZERO_LCK = 1'b1;

  // Storage sizes
  localparam int unsigned GLYPH_DEPTH = 256;
  localparam int unsigned PAL_DEPTH   = 8;

  // Character code classes
  localparam logic [7:0] CODE_NUL      = 8'h00;
  localparam logic [7:0] PAL_CODE_LO   = 8'h08;
  localparam logic [7:0] PAL_CODE_HI   = 8'h0F;
  localparam logic [7:0] LOW_CODE_END  = 8'h20;
  localparam logic [7:0] CODE_SPACE    = 8'h20;
  localparam logic [7:0] HIGH_CODE_LO  = 8'h80;
  localparam logic [7:0] HIGH_CODE_HI  = 8'hA7;
  localparam logic [7:0] HIGH_OFFSET   = 8'h40;

  // Quad widths
  localparam logic [4:0] QUAD_NARROW = 5'd16;
  localparam logic [4:0] QUAD_WIDE   = 5'd24;

  localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

  // Divide by three: q = (s * 683) >> 11, exact for s <= 765
  localparam logic [9:0] GREY_RECIP = 10'd683;
  localparam int unsigned GREY_SHIFT = 11;

  // One glyph table entry
  typedef struct packed {
    logic signed [7:0] adv;
    logic signed [7:0] dy;
    logic [7:0]        v;
    logic [7:0]        u;
  } glyph_t;

endpackage

[hw/rtl/gsl_in_if.sv]
`timescale 1ns / 1ps

interface gsl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         index;
  logic [7:0]         glyph_u;
  logic [7:0]         glyph_v;
  logic signed [7:0]  glyph_dy;
  logic signed [7:0]  glyph_adv;
  logic [31:0]        palette_word;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [31:0]        start_color;
  logic signed [16:0] char_limit;
  logic [31:0]        texture_handle;

  modport source (
    output valid, func, index, glyph_u, glyph_v, glyph_dy, glyph_adv,
           palette_word, start_x, start_y, start_color, char_limit, texture_handle,
    input  ready
  );

  modport sink (
    input  valid, func, index, glyph_u, glyph_v, glyph_dy, glyph_adv,
           palette_word, start_x, start_y, start_color, char_limit, texture_handle,
    output ready
  );
endinterface

[hw/rtl/gsl_out_if.sv]
`timescale 1ns / 1ps

interface gsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dest_x;
  logic signed [15:0] dest_y;
  logic [4:0]         quad_width;
  logic [7:0]         src_u;
  logic [7:0]         src_v;
  logic [31:0]        draw_color;
  logic [31:0]        texture_out;

  modport source (
    output valid, dest_x, dest_y, quad_width, src_u, src_v, draw_color, texture_out,
    input  ready
  );

  modport sink (
    input  valid, dest_x, dest_y, quad_width, src_u, src_v, draw_color, texture_out,
    output ready
  );
endinterface

[hw/rtl/glyph_string_layout_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    func, index, glyph fields, palette word, start fields
// out_o     out  valid/ready    dest_x/y, quad_width, src_u/v, draw_color, texture_out
// APB       in   psel/penable   two 1-bit registers at byte addresses 0 and 4
//
// One word is taken per cycle. A word reads the glyph table (two read ports) at
// acceptance and is resolved in the registered resolve stage, where the pen, color
// and limit state are updated in order; a draw word lands in the output register.
// No clearing pass follows reset; the reset values are in the state registers.
// Input ready drops only while a draw word waits on a full, stalled output.

module glyph_string_layout_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsl_in_if.sink      in_i,
  gsl_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic pal_codes_en_q;
  logic pal_zero_lck_q;

  // Glyph table and its registered read data
  localparam int unsigned GLYPH_DEPTH_L = gsl_pkg::GLYPH_DEPTH;
  logic [31:0] glyph_mem [GLYPH_DEPTH_L];
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;

  // Palette
  logic [31:0] pal_q [gsl_pkg::PAL_DEPTH];

  // Resolve stage word
  logic               s1_valid_q;
  logic [1:0]         s1_func_q;
  logic [7:0]         s1_index_q;
  logic [31:0]        s1_pal_word_q;
  logic [15:0]        s1_x_q;
  logic [15:0]        s1_y_q;
  logic [31:0]        s1_color_q;
  logic signed [16:0] s1_limit_q;
  logic [31:0]        s1_tex_q;

  // String state
  logic [15:0]        pen_x_q, pen_x_d;
  logic [15:0]        pen_y_q, pen_y_d;
  logic [31:0]        color_q, color_d;
  logic signed [16:0] remaining_q, remaining_d;
  logic               active_q, active_d;
  logic [31:0]        tex_q, tex_d;

  // Output register
  logic        out_valid_q;
  logic [15:0] out_x_q;
  logic [15:0] out_y_q;
  logic [4:0]  out_w_q;
  logic [7:0]  out_u_q;
  logic [7:0]  out_v_q;
  logic [31:0] out_color_q;
  logic [31:0] out_tex_q;

  logic in_acc;
  logic s1_go;
  logic emit;

  gsl_pkg::glyph_t ent_a;
  gsl_pkg::glyph_t ent_b;
  gsl_pkg::glyph_t ent_sel;

  logic [9:0]  grey_sum;
  logic [19:0] grey_prod;
  logic [7:0]  grey_q;
  logic [31:0] grey_color;

  logic        is_char;
  logic        is_nul;
  logic        is_pal;
  logic        is_high;
  logic        is_low;
  logic        is_space;
  logic        has_glyph;

  logic [15:0] emit_x;
  logic [15:0] emit_y;
  logic [4:0]  emit_w;
  logic [31:0] emit_color;

  logic        pal_we;
  logic [2:0]  pal_waddr;
  logic [31:0] pal_wdata;

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == gsl_pkg::REG_PAL_ZERO_LCK) ? {31'b0, pal_zero_lck_q}
                                                          : {31'b0, pal_codes_en_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_codes_en_q <= 1'b0;
      pal_zero_lck_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == gsl_pkg::REG_PAL_CODES_EN) begin
        pal_codes_en_q <= pwdata[0];
      end else begin
        pal_zero_lck_q <= pwdata[0];
      end
    end
  end

  // Handshake: the resolve stage retires unless a draw word meets a stalled output
  assign s1_go       = s1_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_go;
  assign in_acc      = in_i.valid && in_i.ready;

  // Glyph table: write on load, read both entries of every accepted word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_i.func == gsl_pkg::FUNC_LOAD_GLYPH) begin
        glyph_mem[in_i.index] <= {in_i.glyph_adv, in_i.glyph_dy, in_i.glyph_v, in_i.glyph_u};
      end
      rd_a_q <= glyph_mem[in_i.index];
      rd_b_q <= glyph_mem[in_i.index + gsl_pkg::HIGH_OFFSET];
    end
  end

  // Capture the word into the resolve stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q     <= in_i.func;
      s1_index_q    <= in_i.index;
      s1_pal_word_q <= in_i.palette_word;
      s1_x_q        <= in_i.start_x;
      s1_y_q        <= in_i.start_y;
      s1_color_q    <= in_i.start_color;
      s1_limit_q    <= in_i.char_limit;
      s1_tex_q      <= in_i.texture_handle;
    end
  end

  // Classify the character
  assign ent_a = gsl_pkg::glyph_t'(rd_a_q);
  assign ent_b = gsl_pkg::glyph_t'(rd_b_q);

  always_comb begin
    is_char   = s1_valid_q && (s1_func_q == gsl_pkg::FUNC_CHAR) && active_q;
    is_nul    = (s1_index_q == gsl_pkg::CODE_NUL);
    is_pal    = s1_index_q inside {[gsl_pkg::PAL_CODE_LO:gsl_pkg::PAL_CODE_HI]};
    is_high   = s1_index_q inside {[gsl_pkg::HIGH_CODE_LO:gsl_pkg::HIGH_CODE_HI]};
    is_low    = (s1_index_q < gsl_pkg::LOW_CODE_END);
    is_space  = (s1_index_q == gsl_pkg::CODE_SPACE);
    has_glyph = (ent_a.adv != 8'sd0);
    emit      = is_char && !is_nul && !is_pal && has_glyph && !is_space;
  end

  // Grey level: average of r, g and b through a reciprocal multiply
  assign grey_sum   = {2'b0, color_q[7:0]} + {2'b0, color_q[15:8]} + {2'b0, color_q[23:16]};
  assign grey_prod  = grey_sum * gsl_pkg::GREY_RECIP;
  assign grey_q     = grey_prod[gsl_pkg::GREY_SHIFT +: 8];
  assign grey_color = (color_q & gsl_pkg::ALPHA_MASK) | {8'b0, grey_q, grey_q, grey_q};

  // Form the draw word
  always_comb begin
    ent_sel    = ent_a;
    emit_x     = pen_x_q;
    emit_w     = gsl_pkg::QUAD_NARROW;
    emit_color = color_q;
    if (is_high) begin
      ent_sel = ent_b;
      emit_x  = pen_x_q + {{8{ent_b.adv[7]}}, ent_b.adv};
    end else if (is_low) begin
      emit_w     = gsl_pkg::QUAD_WIDE;
      emit_color = grey_color;
    end
    emit_y = pen_y_q + {{8{ent_sel.dy[7]}}, ent_sel.dy};
  end

  // Next string state and palette writes
  always_comb begin
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    color_d     = color_q;
    remaining_d = remaining_q;
    active_d    = active_q;
    tex_d       = tex_q;
    pal_we      = 1'b0;
    pal_waddr   = s1_index_q[2:0];
    pal_wdata   = s1_pal_word_q;
    case (gsl_pkg::func_e'(s1_func_q))
      gsl_pkg::FUNC_LOAD_PAL: begin
        pal_we = (s1_index_q < 8'(gsl_pkg::PAL_DEPTH));
      end
      gsl_pkg::FUNC_START: begin
        color_d     = s1_color_q;
        pal_we      = !pal_zero_lck_q;
        pal_waddr   = 3'd0;
        pal_wdata   = s1_color_q;
        pen_x_d     = s1_x_q;
        pen_y_d     = s1_y_q;
        remaining_d = s1_limit_q;
        tex_d       = s1_tex_q;
        active_d    = (s1_limit_q != 17'sd0);
      end
      gsl_pkg::FUNC_CHAR: begin
        if (active_q) begin
          if (is_nul) begin
            active_d = 1'b0;
          end else begin
            if (is_pal) begin
              if (pal_codes_en_q) begin
                color_d = (color_q & gsl_pkg::ALPHA_MASK) | pal_q[s1_index_q[2:0]];
              end
            end else if (has_glyph) begin
              pen_x_d = pen_x_q + {{8{ent_a.adv[7]}}, ent_a.adv};
            end
            // Count down a positive limit and end the string at zero
            if (remaining_q > 17'sd0) begin
              remaining_d = remaining_q - 17'sd1;
              if (remaining_q == 17'sd1) begin
                active_d = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      color_q     <= '0;
      remaining_q <= '0;
      active_q    <= 1'b0;
      tex_q       <= '0;
    end else if (s1_go) begin
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      color_q     <= color_d;
      remaining_q <= remaining_d;
      active_q    <= active_d;
      tex_q       <= tex_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && pal_we) begin
      pal_q[pal_waddr] <= pal_wdata;
    end
  end

  // Output register: load a draw word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && emit) begin
      out_x_q     <= emit_x;
      out_y_q     <= emit_y;
      out_w_q     <= emit_w;
      out_u_q     <= ent_sel.u;
      out_v_q     <= ent_sel.v;
      out_color_q <= emit_color;
      out_tex_q   <= tex_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.dest_x      = out_x_q;
  assign out_o.dest_y      = out_y_q;
  assign out_o.quad_width  = out_w_q;
  assign out_o.src_u       = out_u_q;
  assign out_o.src_v       = out_v_q;
  assign out_o.draw_color  = out_color_q;
  assign out_o.texture_out = out_tex_q;

endmodule
